// ===== hdl/scsa_pkg.sv =====
// Shared types, constants and helpers for the size-class slab allocator.
`timescale 1ns / 1ps
package scsa_pkg;

    // Pool geometry
    localparam int unsigned POOL_PAGES  = 16;
    localparam int unsigned CLASS_COUNT = 9;
    localparam int unsigned GRAN_W      = 12;
    localparam int unsigned PAGE_W      = 5;

    typedef logic [3:0]        t_class;
    typedef logic [GRAN_W-1:0] t_gran;

    localparam t_class TOP_CLASS = t_class'(CLASS_COUNT - 1);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_LINK,
        S_SPLIT
    } t_state;

    // Link store access for one cycle
    typedef struct packed {
        logic  we;
        t_gran waddr;
        t_gran wdata;
        t_gran raddr;
    } t_mem_req;

    // First class whose slot size exceeds the byte count; class 9 means too large
    function automatic t_class size_class(input logic [15:0] bytes);
        t_class c;
        c = t_class'(CLASS_COUNT);
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (bytes < (17'd16 << i)) begin
                c = t_class'(i);
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/scsa_if.sv =====
// Request and response channel interfaces of the allocator.
`timescale 1ns / 1ps
interface scsa_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] request_size;
    logic [15:0] slot_address;

    modport source (output valid, operation, request_size, slot_address, input ready);
    modport sink   (input valid, operation, request_size, slot_address, output ready);
endinterface

interface scsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_address;
    logic [1:0]  status;

    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

// ===== hdl/size_class_slab_allocator.sv =====
// Usage notes:
// Slab allocator over a pool of 4096-byte pages split into nine size classes
// (16 to 4096 bytes), each a FIFO free list linked through a per-granule store.
// i_req (sink) takes one item: operation (0 allocate, 1 free), request_size,
// slot_address. o_rsp (source) returns one item per request: granted_address
// and status (0 ok, 1 too large, 2 pool exhausted).
// Sequence: a free or a rejected request is finished in dispatch. An
// allocation goes through dispatch, pop, a link step for the registered
// link-store read when the popped list holds more than one slot, and the
// split state, which splits one class per step on the way down (0 to 8
// classes) and then loads the result. One item is in work at a time; a new item is taken once
// the sequencer is back in idle, even while the previous result still waits
// in the output register.
// Reset: all lists empty, no pages handed out; no clearing pass is needed,
// the link store is only read behind a written tail.
// Stall: a held o_rsp keeps its result; a finished item then waits in the
// sequencer until the output register frees, without touching any state.
`timescale 1ns / 1ps
module size_class_slab_allocator
    import scsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    scsa_req_if.sink   i_req,
    scsa_rsp_if.source o_rsp
);

    t_state r_state, n_state;

    // Item being worked on
    logic        r_op;
    t_class      r_k;
    logic [15:0] r_addr;
    t_class      r_j;
    t_gran       r_g;

    // List heads, tails and empty flags; page counter
    t_gran              r_head  [CLASS_COUNT];
    t_gran              r_tail  [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] r_empty;
    logic [PAGE_W-1:0]  r_pages;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_addr;
    logic [1:0]  r_out_status;

    t_mem_req w_mem;
    t_gran    w_rdata;

    logic     w_out_free;
    logic     w_big;
    logic     w_found;
    t_class   w_found_cls;
    logic     w_exhausted;
    logic     w_short;
    t_class   w_m;
    logic     w_done;

    scsa_link_mem u_link (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_big       = (r_k == t_class'(CLASS_COUNT));
    assign w_exhausted = (r_pages >= PAGE_W'(POOL_PAGES));
    assign w_m         = r_j - t_class'(1);

    // Nearest non-empty class at or above the request's class
    always_comb begin
        w_found     = 1'b0;
        w_found_cls = TOP_CLASS;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if ((t_class'(c) >= r_k) && !r_empty[c]) begin
                w_found     = 1'b1;
                w_found_cls = t_class'(c);
            end
        end
    end

    // Items finished straight from dispatch
    assign w_short = w_big || (r_op == OP_FREE) || (!w_found && w_exhausted);

    // Result loaded into the output register this cycle
    assign w_done = w_out_free && (((r_state == S_DISPATCH) && w_short)
                                   || ((r_state == S_SPLIT) && (r_j == r_k)));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (!w_short)        n_state = S_POP;
                else if (w_out_free) n_state = S_IDLE;
            end
            S_POP: begin
                n_state = (r_head[r_j] == r_tail[r_j]) ? S_SPLIT : S_LINK;
            end
            S_LINK: begin
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (r_j != r_k)     n_state = S_SPLIT;
                else if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and link store access
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_mem.we    = (r_state == S_DISPATCH) && !w_big && (r_op == OP_FREE)
                      && !r_empty[r_k] && w_out_free;
        w_mem.waddr = r_tail[r_k];
        w_mem.wdata = r_addr[15:4];
        w_mem.raddr = r_head[r_j];
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.granted_address = r_out_addr;
    assign o_rsp.status          = r_out_status;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Control state: empty flags, pages, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty     <= '1;
            r_pages     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done)           r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_DISPATCH: begin
                    if (w_short) begin
                        if (w_out_free && !w_big && (r_op == OP_FREE)) begin
                            r_empty[r_k] <= 1'b0;
                        end
                    end else if (!w_found) begin
                        r_empty[TOP_CLASS] <= 1'b0;
                        r_pages            <= r_pages + PAGE_W'(1);
                    end
                end
                S_POP: begin
                    if (r_head[r_j] == r_tail[r_j]) r_empty[r_j] <= 1'b1;
                end
                S_SPLIT: begin
                    if (r_j != r_k) r_empty[w_m] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload and list pointers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    r_op   <= i_req.operation;
                    r_k    <= size_class(i_req.request_size);
                    r_addr <= i_req.slot_address;
                end
            end
            S_DISPATCH: begin
                if (w_short) begin
                    if (w_out_free) begin
                        r_out_addr <= (r_op == OP_FREE) ? r_addr : 16'd0;
                        if (w_big) begin
                            r_out_status <= STAT_TOO_LARGE;
                        end else if (r_op == OP_FREE) begin
                            r_out_status <= STAT_OK;
                            if (r_empty[r_k]) r_head[r_k] <= r_addr[15:4];
                            r_tail[r_k] <= r_addr[15:4];
                        end else begin
                            r_out_status <= STAT_EXHAUSTED;
                        end
                    end
                end else if (w_found) begin
                    r_j <= w_found_cls;
                end else begin
                    // fresh page into the top class
                    r_head[TOP_CLASS] <= {r_pages[3:0], 8'd0};
                    r_tail[TOP_CLASS] <= {r_pages[3:0], 8'd0};
                    r_j               <= TOP_CLASS;
                end
            end
            S_POP: begin
                r_g <= r_head[r_j];
            end
            S_LINK: begin
                r_head[r_j] <= w_rdata;
            end
            S_SPLIT: begin
                if (r_j != r_k) begin
                    // first half stays in the smaller class, second half goes on
                    r_head[w_m] <= r_g;
                    r_tail[w_m] <= r_g;
                    r_g         <= r_g + (t_gran'(1) << w_m);
                    r_j         <= w_m;
                end else if (w_out_free) begin
                    r_out_addr   <= {r_g, 4'd0};
                    r_out_status <= STAT_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/scsa_link_mem.sv =====
// Per-granule link store: one write and one registered read per cycle.
`timescale 1ns / 1ps
module scsa_link_mem
    import scsa_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_gran    o_rdata
);

    t_gran r_mem [1 << GRAN_W];
    t_gran r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/scsa_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
`timescale 1ns / 1ps
module scsa_checker
    import scsa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [15:0] i_rsp_addr,
    input logic [1:0]  i_rsp_status
);

    // Status code is one of the three defined
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == STAT_OK || i_rsp_status == STAT_TOO_LARGE
                         || i_rsp_status == STAT_EXHAUSTED))
        else $error("undefined status code");

    // Exhausted pool grants no address
    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == STAT_EXHAUSTED) |-> (i_rsp_addr == 16'd0))
        else $error("exhausted result carries an address");

    // One item in work: no accept right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("second item accepted back to back");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_addr) && $stable(i_rsp_status)))
        else $error("stalled result changed");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_addr   (o_rsp.granted_address),
    .i_rsp_status (o_rsp.status)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the size-class slab allocator.
`timescale 1ns / 1ps
module tb;
    import scsa_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int NUM_CLASSES = 9;

    typedef struct {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_grant;

    typedef struct {
        logic [15:0] addr;
        logic [15:0] size;
    } t_live;

    logic i_clk;
    logic i_rst_n;

    scsa_req_if req_ch();
    scsa_rsp_if rsp_ch();

    size_class_slab_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow of the free lists
    t_gran       link_mem [4096];
    t_gran       list_head [NUM_CLASSES];
    t_gran       list_tail [NUM_CLASSES];
    logic        list_empty [NUM_CLASSES];
    int unsigned pages_taken;

    t_grant pending_grants[$];
    t_live  live_slots[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_cycles;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Returns the class index, or NUM_CLASSES for sizes of 4096 and up
    function automatic int class_of(input logic [15:0] bytes);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if ({1'b0, bytes} < (17'd16 << c)) begin
                return c;
            end
        end
        return NUM_CLASSES;
    endfunction

    function automatic void list_append(input int c, input t_gran g);
        if (list_empty[c]) begin
            list_head[c] = g;
        end else begin
            link_mem[list_tail[c]] = g;
        end
        list_tail[c]  = g;
        list_empty[c] = 1'b0;
    endfunction

    function automatic t_gran list_take(input int c);
        t_gran g;
        g = list_head[c];
        if (g == list_tail[c]) begin
            list_empty[c] = 1'b1;
        end else begin
            list_head[c] = link_mem[g];
        end
        return g;
    endfunction

    // Applies one item to the shadow lists and returns its grant
    function automatic t_grant predict_grant(input logic op, input logic [15:0] size,
                                             input logic [15:0] addr);
        t_grant r;
        int     k;
        int     j;
        t_gran  g;
        k = class_of(size);
        r.addr   = 16'd0;
        r.status = STAT_OK;
        if (op == OP_FREE) begin
            r.addr = addr;
            if (k == NUM_CLASSES) begin
                r.status = STAT_TOO_LARGE;
            end else begin
                list_append(k, addr[15:4]);
            end
            return r;
        end
        if (k == NUM_CLASSES) begin
            r.status = STAT_TOO_LARGE;
            return r;
        end
        j = k;
        while (j < NUM_CLASSES && list_empty[j]) begin
            j++;
        end
        if (j == NUM_CLASSES) begin
            if (pages_taken >= POOL_PAGES) begin
                r.status = STAT_EXHAUSTED;
                return r;
            end
            list_append(NUM_CLASSES - 1, t_gran'(pages_taken * 256));
            pages_taken++;
            j = NUM_CLASSES - 1;
        end
        g = list_take(j);
        for (int m = j - 1; m >= k; m--) begin
            list_append(m, g);
            g = t_gran'(g + (1 << m));
        end
        r.addr = {g, 4'd0};
        return r;
    endfunction

    // Offer one item and hold it until taken
    task automatic send_item(input logic op, input logic [15:0] size,
                             input logic [15:0] addr);
        t_grant r;
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.request_size <= size;
        req_ch.slot_address <= addr;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        r = predict_grant(op, size, addr);
        pending_grants.push_back(r);
        if (op == OP_ALLOC && r.status == STAT_OK) begin
            live_slots.push_back('{addr: r.addr, size: size});
        end
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random size: a bound picked evenly among the class sizes, then a size evenly below it
    function automatic logic [15:0] pick_size();
        return 16'($urandom_range(0, (16 << $urandom_range(0, 8)) - 1));
    endfunction

    task automatic free_live_slot();
        int    idx;
        t_live s;
        idx = $urandom_range(0, live_slots.size() - 1);
        s   = live_slots[idx];
        live_slots.delete(idx);
        // any size of the same class, low address bits as garbage
        send_item(OP_FREE, 16'($urandom_range(class_of(s.size) == 0 ? 0 :
                  8 << class_of(s.size), (16 << class_of(s.size)) - 1)),
                  s.addr | 16'($urandom_range(0, 15)));
    endtask

    task automatic test_directed();
        logic [15:0] a;
        send_item(OP_ALLOC, 16'd4096, 16'd0);
        send_item(OP_ALLOC, 16'hFFFF, 16'hFFFF);
        send_item(OP_FREE, 16'hF000, 16'hABCD);
        send_item(OP_ALLOC, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'd15, 16'd0);
        send_item(OP_ALLOC, 16'd16, 16'd0);
        send_item(OP_ALLOC, 16'd4095, 16'd0);
        send_item(OP_ALLOC, 16'd2047, 16'd0);
        send_item(OP_ALLOC, 16'd1024, 16'd0);
        // free of address zero, unaligned
        send_item(OP_FREE, 16'd10, 16'd7);
        send_item(OP_ALLOC, 16'd1, 16'd0);
        // double free and a further free, each under a class other than the slot's own
        a = live_slots[1].addr;
        send_item(OP_FREE, 16'd20, a);
        send_item(OP_FREE, 16'd20, a);
        send_item(OP_FREE, 16'd300, a | 16'h000F);
        send_item(OP_ALLOC, 16'd17, 16'd0);
        send_item(OP_ALLOC, 16'd31, 16'd0);
        send_item(OP_ALLOC, 16'd256, 16'd0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_item(1'($urandom_range(1)), 16'($urandom_range(4096, 65535)),
                          16'($urandom));
            end else if (r < 10) begin
                // stray free of an arbitrary slot
                send_item(OP_FREE, pick_size(), 16'($urandom));
            end else if (live_slots.size() > 0 && (r < 50 || live_slots.size() > 60)) begin
                free_live_slot();
            end else begin
                send_item(OP_ALLOC, pick_size(), 16'($urandom));
            end
        end
    endtask

    // Large requests until the pool runs dry, then hand some back
    task automatic test_exhaustion();
        for (int n = 0; n < 20; n++) begin
            send_item(OP_ALLOC, 16'($urandom_range(2048, 4095)), 16'd0);
        end
        for (int n = 0; n < 10 && live_slots.size() > 0; n++) begin
            free_live_slot();
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_cycles = 200;
        test_random(12);
        wait_drained();
    endtask

    // Receiver ready, with random stalls or a long hold
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_grant e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result addr=%h status=%0d",
                             rsp_ch.granted_address, rsp_ch.status);
                end
            end else begin
                e = pending_grants.pop_front();
                if (rsp_ch.granted_address !== e.addr || rsp_ch.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                                 e.addr, e.status, rsp_ch.granted_address, rsp_ch.status);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL size_class_slab_allocator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_ALLOC;
        req_ch.request_size = 16'd0;
        req_ch.slot_address = 16'd0;
        rsp_ch.ready        = 1'b0;
        i_rst_n             = 1'b0;
        hold_cycles         = 0;
        mismatches          = 0;
        quiet_cycles        = 0;
        send_idle_pct       = 17;
        recv_idle_pct       = 49;
        pages_taken         = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            list_head[c]  = '0;
            list_tail[c]  = '0;
            list_empty[c] = 1'b1;
        end
        for (int g = 0; g < 4096; g++) begin
            link_mem[g] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(170);
        test_backpressure();
        send_idle_pct = 49;
        recv_idle_pct = 17;
        test_random(170);
        test_exhaustion();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(160);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("PASS size_class_slab_allocator");
        end else begin
            $display("FAIL size_class_slab_allocator");
        end
        $finish;
    end
endmodule
